// ===== rtl/gev_pkg.sv =====
package gev_pkg;

   localparam int DEF_MAX_COLS = 128;
   localparam int DEF_MAX_ROWS = 128;

   localparam int HEIGHT_W   = 4;
   localparam int COUNT_W    = 15;
   localparam int CFG_W      = 8;
   localparam int CSR_IDX_W  = 1;
   // wide enough to compare a size register against any legal MAX_* value
   localparam int SIZE_CMP_W = 11;

   localparam logic [COUNT_W-1:0]   TALLY_MAX  = '1;
   localparam logic [CFG_W-1:0]     SIZE_RESET = 8'd128;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS = 1'b1;

   typedef enum logic [1:0] {
      PASS_ROW_FWD,
      PASS_ROW_REV,
      PASS_COL_FWD,
      PASS_COL_REV
   } pass_type;

   typedef struct packed {
      logic     valid;
      logic     first;   // first cell of a line: running max restarts
      logic     last;    // last cell of the last pass
      pass_type pass;
   } scan_ctl_type;

endpackage

// ===== rtl/gev_ram.sv =====
module gev_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16384
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gev_scan_seq.sv =====
module gev_scan_seq #(
   parameter int MAX_COLS = gev_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = gev_pkg::DEF_MAX_ROWS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [$clog2(MAX_COLS + 1)-1:0]     cols,
   input  logic [$clog2(MAX_ROWS + 1)-1:0]     rows,
   input  logic [((MAX_COLS * MAX_ROWS) > 1 ?
                  $clog2(MAX_COLS * MAX_ROWS) : 1):0] total,
   output gev_pkg::scan_ctl_type               op_ctl,
   output logic [((MAX_COLS * MAX_ROWS) > 1 ?
                  $clog2(MAX_COLS * MAX_ROWS) : 1)-1:0] op_addr
);

   localparam int CELL_CAP = MAX_COLS * MAX_ROWS;
   localparam int AW       = CELL_CAP > 1 ? $clog2(CELL_CAP) : 1;
   localparam int TOTW     = AW + 1;
   localparam int MAX_DIM  = MAX_COLS > MAX_ROWS ? MAX_COLS : MAX_ROWS;
   localparam int DW       = $clog2(MAX_DIM + 1);
   localparam int LW       = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;

   logic             busy_ff, busy_in;
   gev_pkg::pass_type pass_ff, pass_in;
   logic [LW-1:0]    line_ff, line_in;
   logic [LW-1:0]    k_ff, k_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [AW-1:0]    base_ff, base_in;

   logic             row_pass;
   logic [DW-1:0]    line_len, line_cnt;
   logic             end_k, end_line;
   logic [AW-1:0]    cols_a, step_addr, next_base, last_row_base;

   always_comb begin
      row_pass  = (pass_ff == gev_pkg::PASS_ROW_FWD) || (pass_ff == gev_pkg::PASS_ROW_REV);
      line_len  = row_pass ? DW'(cols) : DW'(rows);
      line_cnt  = row_pass ? DW'(rows) : DW'(cols);
      end_k     = (DW'(k_ff) == line_len - DW'(1));
      end_line  = (DW'(line_ff) == line_cnt - DW'(1));
      cols_a    = AW'(cols);
      last_row_base = AW'(total - TOTW'(cols));
      next_base = row_pass ? base_ff + cols_a : base_ff + AW'(1);

      case (pass_ff)
         gev_pkg::PASS_ROW_FWD: step_addr = addr_ff + AW'(1);
         gev_pkg::PASS_ROW_REV: step_addr = addr_ff - AW'(1);
         gev_pkg::PASS_COL_FWD: step_addr = addr_ff + cols_a;
         gev_pkg::PASS_COL_REV: step_addr = addr_ff - cols_a;
         default:               step_addr = addr_ff;
      endcase

      busy_in = busy_ff;
      pass_in = pass_ff;
      line_in = line_ff;
      k_in    = k_ff;
      addr_in = addr_ff;
      base_in = base_ff;

      if (start) begin
         busy_in = 1'b1;
         pass_in = gev_pkg::PASS_ROW_FWD;
         line_in = '0;
         k_in    = '0;
         addr_in = '0;
         base_in = '0;
      end else if (busy_ff) begin
         if (!end_k) begin
            k_in    = LW'(k_ff + LW'(1));
            addr_in = step_addr;
         end else if (!end_line) begin
            k_in    = '0;
            line_in = LW'(line_ff + LW'(1));
            base_in = next_base;
            addr_in = next_base;
         end else begin
            k_in    = '0;
            line_in = '0;
            case (pass_ff)
               gev_pkg::PASS_ROW_FWD: begin
                  pass_in = gev_pkg::PASS_ROW_REV;
                  base_in = cols_a - AW'(1);
               end
               gev_pkg::PASS_ROW_REV: begin
                  pass_in = gev_pkg::PASS_COL_FWD;
                  base_in = '0;
               end
               gev_pkg::PASS_COL_FWD: begin
                  pass_in = gev_pkg::PASS_COL_REV;
                  base_in = last_row_base;
               end
               default: begin
                  busy_in = 1'b0;
                  base_in = '0;
               end
            endcase
            addr_in = base_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pass_ff <= gev_pkg::PASS_ROW_FWD;
         line_ff <= '0;
         k_ff    <= '0;
         addr_ff <= '0;
         base_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         pass_ff <= pass_in;
         line_ff <= line_in;
         k_ff    <= k_in;
         addr_ff <= addr_in;
         base_ff <= base_in;
      end
   end

   always_comb begin
      op_ctl.valid = busy_ff;
      op_ctl.first = (k_ff == '0);
      op_ctl.last  = busy_ff && end_k && end_line && (pass_ff == gev_pkg::PASS_COL_REV);
      op_ctl.pass  = pass_ff;
   end

   assign op_addr = addr_ff;

endmodule

// ===== rtl/gev_vis_unit.sv =====
module gev_vis_unit #(
   parameter int MAX_COLS = gev_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = gev_pkg::DEF_MAX_ROWS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 clear,
   input  gev_pkg::scan_ctl_type                op_ctl,
   input  logic [((MAX_COLS * MAX_ROWS) > 1 ?
                  $clog2(MAX_COLS * MAX_ROWS) : 1)-1:0] op_addr,
   input  logic [gev_pkg::HEIGHT_W-1:0]         hgt_rdata,
   input  logic                                 flag_rdata,
   output logic                                 flag_we,
   output logic [((MAX_COLS * MAX_ROWS) > 1 ?
                  $clog2(MAX_COLS * MAX_ROWS) : 1)-1:0] flag_waddr,
   output logic                                 flag_wdata,
   output logic [gev_pkg::COUNT_W-1:0]          tally,
   output logic                                 done
);

   localparam int CELL_CAP = MAX_COLS * MAX_ROWS;
   localparam int AW       = CELL_CAP > 1 ? $clog2(CELL_CAP) : 1;

   gev_pkg::scan_ctl_type              st_ctl_ff;
   logic [AW-1:0]                      st_addr_ff;
   logic                               fwd_hit_ff, fwd_hit_in;
   logic                               fwd_data_ff;
   logic [gev_pkg::HEIGHT_W-1:0]       rmax_ff, rmax_in;
   logic [gev_pkg::COUNT_W-1:0]        tally_ff, tally_in;

   logic taller, old_flag, new_flag;

   always_comb begin
      // first cell of a line beats the below-zero start value
      taller   = st_ctl_ff.first || (hgt_rdata > rmax_ff);
      // turnaround between passes can read the cell being written this cycle
      old_flag = fwd_hit_ff ? fwd_data_ff : flag_rdata;
      // first pass writes every cell, so stale flags never survive a grid
      new_flag = (st_ctl_ff.pass == gev_pkg::PASS_ROW_FWD) ? taller : (old_flag | taller);

      flag_we    = st_ctl_ff.valid;
      flag_waddr = st_addr_ff;
      flag_wdata = new_flag;
      fwd_hit_in = flag_we && (st_addr_ff == op_addr);

      rmax_in = rmax_ff;
      if (st_ctl_ff.valid && taller) begin
         rmax_in = hgt_rdata;
      end

      tally_in = tally_ff;
      if (clear) begin
         tally_in = '0;
      end else if (st_ctl_ff.valid && (st_ctl_ff.pass == gev_pkg::PASS_COL_REV) &&
                   new_flag && (tally_ff != gev_pkg::TALLY_MAX)) begin
         tally_in = tally_ff + gev_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ctl_ff  <= '0;
         fwd_hit_ff <= 1'b0;
         tally_ff   <= '0;
      end else begin
         st_ctl_ff  <= op_ctl;
         fwd_hit_ff <= fwd_hit_in;
         tally_ff   <= tally_in;
      end
      st_addr_ff  <= op_addr;
      fwd_data_ff <= new_flag;
      rmax_ff     <= rmax_in;
   end

   assign tally = tally_ff;
   assign done  = st_ctl_ff.valid && st_ctl_ff.last;

endmodule

// ===== rtl/grid_edge_visibility_count.sv =====
// Load: one height per cycle, req_stall low while a grid is being loaded.
// The last cell starts four scans of the stored grid, one cell per cycle through the
// height and flag RAMs; the count is registered once the last scan is done.
// Requests stall during the scans and the emit, plus any wait for a still-held count.
// Reset clears control and the load counter and sets the size registers (128 x 128);
// the RAMs are not cleared, the first scan of each grid rewrites every flag in use.
module grid_edge_visibility_count #(
   parameter int MAX_COLS = gev_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = gev_pkg::DEF_MAX_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [gev_pkg::HEIGHT_W-1:0]     req_height,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [gev_pkg::COUNT_W-1:0]      rsp_visible_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gev_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gev_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int CELL_CAP = MAX_COLS * MAX_ROWS;
   localparam int AW       = CELL_CAP > 1 ? $clog2(CELL_CAP) : 1;
   localparam int TOTW     = AW + 1;
   localparam int CW       = $clog2(MAX_COLS + 1);
   localparam int RW       = $clog2(MAX_ROWS + 1);
   localparam int CMPW     = gev_pkg::SIZE_CMP_W;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type                    state_ff, state_in;
   logic [gev_pkg::CFG_W-1:0]    grid_cols_ff, grid_cols_in;
   logic [gev_pkg::CFG_W-1:0]    grid_rows_ff, grid_rows_in;
   logic [AW-1:0]                cells_loaded_ff, cells_loaded_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [gev_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [CW-1:0]                cols;
   logic [RW-1:0]                rows;
   logic [CW+RW-1:0]             cell_prod;
   logic [TOTW-1:0]              total, load_idx;
   logic                         req_accept, grid_end, scan_start;

   gev_pkg::scan_ctl_type        op_ctl;
   logic [AW-1:0]                op_addr;
   logic [gev_pkg::HEIGHT_W-1:0] hgt_rdata;
   logic                         flag_rdata, flag_we, flag_wdata;
   logic [AW-1:0]                flag_waddr;
   logic [gev_pkg::COUNT_W-1:0]  tally;
   logic                         scan_done;

   always_comb begin
      // zero reads as one, anything above the cap saturates
      if (grid_cols_ff == '0) begin
         cols = CW'(1);
      end else if (CMPW'(grid_cols_ff) > CMPW'(MAX_COLS)) begin
         cols = CW'(MAX_COLS);
      end else begin
         cols = CW'(grid_cols_ff);
      end
      if (grid_rows_ff == '0) begin
         rows = RW'(1);
      end else if (CMPW'(grid_rows_ff) > CMPW'(MAX_ROWS)) begin
         rows = RW'(MAX_ROWS);
      end else begin
         rows = RW'(grid_rows_ff);
      end
      cell_prod = (CW+RW)'(cols) * (CW+RW)'(rows);
      total     = TOTW'(cell_prod);
      // grid shrunk below the load count: overwrite the last cell and finish
      load_idx  = (TOTW'(cells_loaded_ff) >= total) ? total - TOTW'(1) : TOTW'(cells_loaded_ff);
   end

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign grid_end   = (load_idx + TOTW'(1) == total);
   assign scan_start = req_accept && grid_end;
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in        = state_ff;
      grid_cols_in    = grid_cols_ff;
      grid_rows_in    = grid_rows_ff;
      cells_loaded_in = cells_loaded_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_count_in    = rsp_count_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            gev_pkg::REG_GRID_COLS: grid_cols_in = csr_wdata;
            gev_pkg::REG_GRID_ROWS: grid_rows_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (grid_end) begin
                  cells_loaded_in = '0;
                  state_in        = ST_SCAN;
               end else begin
                  cells_loaded_in = AW'(load_idx + TOTW'(1));
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = tally;
               state_in     = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         grid_cols_ff    <= gev_pkg::SIZE_RESET;
         grid_rows_ff    <= gev_pkg::SIZE_RESET;
         cells_loaded_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         grid_cols_ff    <= grid_cols_in;
         grid_rows_ff    <= grid_rows_in;
         cells_loaded_ff <= cells_loaded_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_visible_count = rsp_count_ff;

   gev_ram #(
      .WIDTH (gev_pkg::HEIGHT_W),
      .DEPTH (CELL_CAP)
   ) u_height_ram (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (load_idx[AW-1:0]),
      .wr_data (req_height),
      .rd_addr (op_addr),
      .rd_data (hgt_rdata)
   );

   gev_ram #(
      .WIDTH (1),
      .DEPTH (CELL_CAP)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (flag_waddr),
      .wr_data (flag_wdata),
      .rd_addr (op_addr),
      .rd_data (flag_rdata)
   );

   gev_scan_seq #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_scan_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .cols    (cols),
      .rows    (rows),
      .total   (total),
      .op_ctl  (op_ctl),
      .op_addr (op_addr)
   );

   gev_vis_unit #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_vis_unit (
      .clock      (clock),
      .reset      (reset),
      .clear      (scan_start),
      .op_ctl     (op_ctl),
      .op_addr    (op_addr),
      .hgt_rdata  (hgt_rdata),
      .flag_rdata (flag_rdata),
      .flag_we    (flag_we),
      .flag_waddr (flag_waddr),
      .flag_wdata (flag_wdata),
      .tally      (tally),
      .done       (scan_done)
   );

endmodule

// ===== rtl/gev_checker.sv =====
module gev_props (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [gev_pkg::COUNT_W-1:0] rsp_visible_count
);

   // a stalled response holds its count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_visible_count))
      else $error("response changed while stalled");

   // every grid has at least one edge cell
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_visible_count != '0)
      else $error("zero visible count");

   // a new count only follows a scan, during which requests are stalled
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without preceding scan");

   // the stall raised for the four scans does not drop straight after it rises
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |=> req_stall ##1 req_stall)
      else $error("scan ended too early");

endmodule

bind grid_edge_visibility_count gev_props u_gev_props (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_visible_count (rsp_visible_count)
);
